FILE: src/rprc_pkg.sv
// ----------------------------------------------------------------------------
// rprc_pkg
// Shared types and constants for the read pileup region clusterer.
// ----------------------------------------------------------------------------
package rprc_pkg;

  localparam int DEF_MAX_REGIONS = 32;
  localparam int DEF_SPAN_LIMIT  = 8192;

  localparam int POS_W   = 31;
  localparam int COORD_W = 32;
  localparam int SUM_W   = 48;
  localparam int TALLY_W = 32;
  localparam int SPAN_W  = 10;
  localparam int LIMIT_W = 16;
  localparam int KEPT_W  = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [SPAN_W-1:0]  READ_SPAN_RST  = SPAN_W'(50);
  localparam logic [LIMIT_W-1:0] MEAN_LIMIT_RST = LIMIT_W'(20);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_READ_SPAN  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MEAN_LIMIT = CFG_IDX_W'(1);

  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] right;
    logic [SUM_W-1:0]   sum;
    logic [TALLY_W-1:0] tally;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PLACE,
    ST_RPT,
    ST_SUMMARY
  } state_t;

endpackage

FILE: src/rprc_merge.sv
// ----------------------------------------------------------------------------
// rprc_merge
// Two-stage merge of one read into one table entry read from memory:
// containment test, right extension, tally and covered-base count, then
// saturating base-sum add and write-back.
// ----------------------------------------------------------------------------
module rprc_merge #(
  parameter int MAX_REGIONS = rprc_pkg::DEF_MAX_REGIONS,
  parameter int SPAN_LIMIT  = rprc_pkg::DEF_SPAN_LIMIT,
  localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic [IDX_W-1:0]              in_idx,
  input  rprc_pkg::entry_t              in_ent,
  input  logic [rprc_pkg::COORD_W-1:0]  rd_pos,
  input  logic [rprc_pkg::COORD_W-1:0]  rd_end,
  output logic                          wb_vld,
  output logic [IDX_W-1:0]              wb_idx,
  output rprc_pkg::entry_t              wb_ent,
  output logic                          stage_busy
);
  import rprc_pkg::*;

  localparam int COV_W = $clog2(SPAN_LIMIT + 1);
  localparam logic [COORD_W-1:0] CLIP = COORD_W'(SPAN_LIMIT - 1);

  logic [COORD_W-1:0] lo, hi, top;
  logic [COV_W-1:0]   cov;
  logic               hit;
  entry_t             upd;

  logic               a_vld_r;
  logic               a_hit_r;
  logic [IDX_W-1:0]   a_idx_r;
  entry_t             a_ent_r;
  logic [COV_W-1:0]   a_cov_r;
  logic [SUM_W:0]     sum_ext;

  always_comb begin
    hit = (rd_pos >= in_ent.left) && (rd_pos <= in_ent.right);
    lo  = rd_pos - in_ent.left;
    hi  = rd_end - in_ent.left;
    top = (hi > CLIP) ? CLIP : hi;
    // offsets beyond the span limit add nothing
    cov = (lo > top) ? '0 : (COV_W'(top) - COV_W'(lo) + COV_W'(1));
    upd = in_ent;
    if (rd_end > in_ent.right) begin
      upd.right = rd_end;
    end
    if (in_ent.tally != '1) begin
      upd.tally = in_ent.tally + TALLY_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
    end
    a_hit_r <= hit;
    a_idx_r <= in_idx;
    a_ent_r <= upd;
    a_cov_r <= cov;
  end

  always_comb begin
    sum_ext = {1'b0, a_ent_r.sum} + (SUM_W + 1)'(a_cov_r);
    wb_ent = a_ent_r;
    wb_ent.sum = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
  end

  assign wb_vld     = a_vld_r && a_hit_r;
  assign wb_idx     = a_idx_r;
  assign stage_busy = a_vld_r;

endmodule

FILE: src/read_pileup_region_clusterer_unit.sv
// ----------------------------------------------------------------------------
// read_pileup_region_clusterer_unit
// Clusters sorted read positions into regions held in one entry memory and,
// on the last read, reports regions whose base sum beats limit * width.
// ----------------------------------------------------------------------------
// A read with stored regions is compared with each of them; the memory port visits
//   one entry per cycle, and a read with an empty table goes straight to placement.
// A last read then reads every region again for the report;
//   region words and the summary word follow one per cycle at most.
// One read at a time; results carry a one-cycle strobe, the receiver cannot stall.
// Reset (rst_n low, synchronous) empties the table and restores the registers;
//   memory contents need no clearing.
// ----------------------------------------------------------------------------
module read_pileup_region_clusterer_unit #(
  parameter int MAX_REGIONS = rprc_pkg::DEF_MAX_REGIONS,
  parameter int SPAN_LIMIT  = rprc_pkg::DEF_SPAN_LIMIT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [rprc_pkg::POS_W-1:0]        in_read_position,
  input  logic                              in_last_read,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rprc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rprc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              out_strobe,
  output logic [rprc_pkg::COORD_W-1:0]      out_region_left,
  output logic [rprc_pkg::COORD_W-1:0]      out_region_right,
  output logic [rprc_pkg::TALLY_W-1:0]      out_region_reads,
  output logic                              out_is_summary,
  output logic [rprc_pkg::KEPT_W-1:0]       out_kept_count,
  output logic                              out_table_overflow,
  output logic                              out_last
);
  import rprc_pkg::*;

  localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REGIONS);
  localparam int PROD_W = LIMIT_W + COORD_W;

  state_t state_r, state_nxt;

  logic [COORD_W-1:0] pos_r, end_r;
  logic               fin_r;
  logic [CNT_W-1:0]   used_r, iss_r, kept_r;
  logic               ovf_r, hit_r;
  logic [SPAN_W-1:0]  span_r;
  logic [LIMIT_W-1:0] limit_r;

  // entry memory
  entry_t             mem [MAX_REGIONS];
  entry_t             rdata_r;
  logic               rvld_r;
  logic               rd_en;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa;
  entry_t             mem_wd;
  logic [IDX_W-1:0]   rd_idx;
  logic [IDX_W-1:0]   rdata_idx_r;

  // merge pipeline
  logic               wb_vld;
  logic [IDX_W-1:0]   wb_idx;
  entry_t             wb_ent;
  logic               mrg_busy;

  // report pipeline
  logic               r1_vld_r, r2_vld_r;
  entry_t             r1_ent_r, r2_ent_r;
  logic [COORD_W-1:0] r1_wid_r;
  logic [PROD_W-1:0]  r2_bar_r;

  logic               accept;
  logic               scanning, reporting;
  logic               place_we;
  logic [SUM_W-1:0]   new_sum;
  logic               keep;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = !busy;
  assign scanning  = (state_r == ST_SCAN);
  assign reporting = (state_r == ST_RPT);
  assign rd_en     = (scanning || reporting) && (iss_r < used_r);
  assign place_we  = (state_r == ST_PLACE) && !hit_r && (used_r < CNT_MAX);
  assign new_sum   = (COORD_W'(span_r) > COORD_W'(SPAN_LIMIT - 1)) ?
                     SUM_W'(SPAN_LIMIT) : (SUM_W'(span_r) + SUM_W'(1));
  assign keep      = r2_vld_r && (r2_ent_r.sum > r2_bar_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_wa    = wb_idx;
    mem_wd    = wb_ent;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (used_r == '0) ? ST_PLACE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        mem_we = wb_vld;
        if (!rd_en && !rvld_r && !mrg_busy) begin
          state_nxt = ST_PLACE;
        end
      end
      ST_PLACE: begin
        mem_we       = place_we;
        mem_wa       = used_r[IDX_W-1:0];
        mem_wd.left  = pos_r;
        mem_wd.right = end_r;
        mem_wd.sum   = new_sum;
        mem_wd.tally = TALLY_W'(1);
        state_nxt    = fin_r ? ST_RPT : ST_IDLE;
      end
      ST_RPT: begin
        if (!rd_en && !rvld_r && !r1_vld_r && !r2_vld_r) begin
          state_nxt = ST_SUMMARY;
        end
      end
      ST_SUMMARY: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // memory: one read port, one write port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_idx];
    end
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  assign rd_idx = iss_r[IDX_W-1:0];

  rprc_merge #(
    .MAX_REGIONS (MAX_REGIONS),
    .SPAN_LIMIT  (SPAN_LIMIT)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (rvld_r && scanning),
    .in_idx     (rdata_idx_r),
    .in_ent     (rdata_r),
    .rd_pos     (pos_r),
    .rd_end     (end_r),
    .wb_vld     (wb_vld),
    .wb_idx     (wb_idx),
    .wb_ent     (wb_ent),
    .stage_busy (mrg_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvld_r   <= 1'b0;
      r1_vld_r <= 1'b0;
      r2_vld_r <= 1'b0;
    end else begin
      rvld_r   <= rd_en;
      r1_vld_r <= rvld_r && reporting;
      r2_vld_r <= r1_vld_r;
    end
    rdata_idx_r <= rd_idx;
    r1_ent_r    <= rdata_r;
    r1_wid_r    <= rdata_r.right - rdata_r.left;
    r2_ent_r    <= r1_ent_r;
    r2_bar_r    <= PROD_W'(limit_r) * PROD_W'(r1_wid_r);
  end

  // control and table bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      ovf_r   <= 1'b0;
      hit_r   <= 1'b0;
      iss_r   <= '0;
      kept_r  <= '0;
      span_r  <= READ_SPAN_RST;
      limit_r <= MEAN_LIMIT_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_READ_SPAN:  span_r  <= cfg_data[SPAN_W-1:0];
          CFG_MEAN_LIMIT: limit_r <= cfg_data[LIMIT_W-1:0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        hit_r <= 1'b0;
        iss_r <= '0;
      end else if (rd_en) begin
        iss_r <= iss_r + CNT_W'(1);
      end
      if (wb_vld && scanning) begin
        hit_r <= 1'b1;
      end
      if (state_r == ST_PLACE) begin
        iss_r <= '0;
        if (!hit_r) begin
          if (used_r < CNT_MAX) begin
            used_r <= used_r + CNT_W'(1);
          end else begin
            ovf_r <= 1'b1;
          end
        end
      end
      if (keep) begin
        kept_r <= kept_r + CNT_W'(1);
      end
      // close the run: empty the table for the next one
      if (state_r == ST_SUMMARY) begin
        used_r <= '0;
        ovf_r  <= 1'b0;
        kept_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos_r <= COORD_W'(in_read_position);
      end_r <= COORD_W'(in_read_position) + COORD_W'(span_r);
      fin_r <= in_last_read;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= keep || (state_r == ST_SUMMARY);
    end
    if (state_r == ST_SUMMARY) begin
      out_region_left    <= '0;
      out_region_right   <= '0;
      out_region_reads   <= '0;
      out_is_summary     <= 1'b1;
      out_kept_count     <= KEPT_W'(kept_r);
      out_table_overflow <= ovf_r;
      out_last           <= 1'b1;
    end else begin
      out_region_left    <= r2_ent_r.left;
      out_region_right   <= r2_ent_r.right;
      out_region_reads   <= r2_ent_r.tally;
      out_is_summary     <= 1'b0;
      out_kept_count     <= '0;
      out_table_overflow <= 1'b0;
      out_last           <= 1'b0;
    end
  end

endmodule

FILE: tb/region_report_checker.sv
// ----------------------------------------------------------------------------
// region_report_checker
// Follows the read, register and report words on the clusterer's ports,
// keeps its own copy of the region table and compares every report word,
// in order and field by field, with the words it predicts.
// ----------------------------------------------------------------------------
module region_report_checker #(
  parameter int MAX_REGIONS = rprc_pkg::DEF_MAX_REGIONS,
  parameter int SPAN_LIMIT  = rprc_pkg::DEF_SPAN_LIMIT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              busy,
  input  logic [rprc_pkg::POS_W-1:0]        in_read_position,
  input  logic                              in_last_read,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [rprc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rprc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              out_strobe,
  input  logic [rprc_pkg::COORD_W-1:0]      out_region_left,
  input  logic [rprc_pkg::COORD_W-1:0]      out_region_right,
  input  logic [rprc_pkg::TALLY_W-1:0]      out_region_reads,
  input  logic                              out_is_summary,
  input  logic [rprc_pkg::KEPT_W-1:0]       out_kept_count,
  input  logic                              out_table_overflow,
  input  logic                              out_last,
  output int unsigned                       words_due,
  output int unsigned                       fail_count
);
  import rprc_pkg::*;

  typedef struct {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] right;
    logic [TALLY_W-1:0] reads;
    logic               is_summary;
    logic [KEPT_W-1:0]  kept;
    logic               overflow;
    logic               last;
  } report_word_t;

  entry_t             region_tab [MAX_REGIONS];
  int unsigned        regions_open;
  logic               reads_dropped;
  logic [SPAN_W-1:0]  span_reg;
  logic [LIMIT_W-1:0] limit_reg;
  report_word_t       expected_words [$];
  report_word_t       head;
  int unsigned        errors = 0;

  // bases covered by offsets lo..hi, clipped at the span limit
  function automatic logic [SUM_W-1:0] bases_in(logic [COORD_W-1:0] lo,
                                                logic [COORD_W-1:0] hi);
    logic [COORD_W-1:0] clip_hi;
    clip_hi = (hi > COORD_W'(SPAN_LIMIT - 1)) ? COORD_W'(SPAN_LIMIT - 1) : hi;
    if (lo > clip_hi) return '0;
    return SUM_W'(clip_hi - lo) + SUM_W'(1);
  endfunction

  function automatic int field_wrong(string name, logic [COORD_W-1:0] want,
                                     logic [COORD_W-1:0] got);
    if (got === want) return 0;
    $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    return 1;
  endfunction

  task automatic absorb_read(logic [POS_W-1:0] pos);
    logic [COORD_W-1:0] p;
    logic [COORD_W-1:0] stop;
    logic [SUM_W:0]     grown;
    bit                 hit;
    p    = COORD_W'(pos);
    stop = p + COORD_W'(span_reg);
    hit  = 1'b0;
    for (int k = 0; k < regions_open; k++) begin
      if (p >= region_tab[k].left && p <= region_tab[k].right) begin
        hit = 1'b1;
        if (stop > region_tab[k].right) region_tab[k].right = stop;
        if (region_tab[k].tally != '1) region_tab[k].tally += 1;
        grown = {1'b0, region_tab[k].sum}
              + {1'b0, bases_in(p - region_tab[k].left, stop - region_tab[k].left)};
        region_tab[k].sum = grown[SUM_W] ? '1 : grown[SUM_W-1:0];
      end
    end
    if (!hit) begin
      if (regions_open >= MAX_REGIONS) begin
        reads_dropped = 1'b1;
      end else begin
        region_tab[regions_open].left  = p;
        region_tab[regions_open].right = stop;
        region_tab[regions_open].sum   = bases_in('0, COORD_W'(span_reg));
        region_tab[regions_open].tally = TALLY_W'(1);
        regions_open++;
      end
    end
  endtask

  task automatic queue_report();
    report_word_t      w;
    logic [SUM_W-1:0]  bar;
    logic [KEPT_W-1:0] kept;
    kept = '0;
    for (int k = 0; k < regions_open; k++) begin
      bar = SUM_W'(limit_reg) * SUM_W'(region_tab[k].right - region_tab[k].left);
      if (region_tab[k].sum > bar) begin
        w = '{left: region_tab[k].left, right: region_tab[k].right,
              reads: region_tab[k].tally, is_summary: 1'b0, kept: '0,
              overflow: 1'b0, last: 1'b0};
        expected_words = {expected_words, w};
        kept++;
      end
    end
    w = '{left: '0, right: '0, reads: '0, is_summary: 1'b1, kept: kept,
          overflow: reads_dropped, last: 1'b1};
    expected_words = {expected_words, w};
    // the report empties the table for the next run
    regions_open  = 0;
    reads_dropped = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      regions_open  = 0;
      reads_dropped = 1'b0;
      span_reg      = READ_SPAN_RST;
      limit_reg     = MEAN_LIMIT_RST;
      expected_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_READ_SPAN:  span_reg  = cfg_data[SPAN_W-1:0];
          CFG_MEAN_LIMIT: limit_reg = cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (out_strobe) begin
        if (expected_words.size() == 0) begin
          $display("%0t: report word mismatch: expected none, actual left %0h right %0h",
                   $time, out_region_left, out_region_right);
          $display("  reads %0h summary %0b kept %0d overflow %0b last %0b",
                   out_region_reads, out_is_summary, out_kept_count,
                   out_table_overflow, out_last);
          errors++;
        end else begin
          head = expected_words.pop_front();
          errors += field_wrong("region_left", head.left, out_region_left);
          errors += field_wrong("region_right", head.right, out_region_right);
          errors += field_wrong("region_reads", head.reads, out_region_reads);
          errors += field_wrong("is_summary", head.is_summary, out_is_summary);
          errors += field_wrong("kept_count", head.kept, out_kept_count);
          errors += field_wrong("table_overflow", head.overflow, out_table_overflow);
          errors += field_wrong("last", head.last, out_last);
        end
      end
      if (start && !busy) begin
        absorb_read(in_read_position);
        if (in_last_read) queue_report();
      end
    end
    words_due  <= expected_words.size();
    fail_count <= errors;
  end

endmodule

FILE: tb/read_pileup_region_clusterer_unit_test.sv
// ----------------------------------------------------------------------------
// read_pileup_region_clusterer_unit_test
// Feeds runs of read positions, each closed by a last read, into the region
// clusterer under several register settings and sender gap rates; the
// report words are checked by region_report_checker beside the block.
// ----------------------------------------------------------------------------
module read_pileup_region_clusterer_unit_test;
  import rprc_pkg::*;

  localparam int DRAIN_CYCLES = 48;
  localparam int STALL_LIMIT  = 3000;
  localparam int RANDOM_READS = 180;
  localparam int PHASES       = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = CFG_IDX_W'(3);
  localparam logic [POS_W-1:0]     POS_TOP      = '1;

  typedef enum {RUN_PILEUP, RUN_SCATTER, RUN_SHUFFLED} run_kind_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic [POS_W-1:0]      in_read_position = '0;
  logic                  in_last_read = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  busy;
  logic                  cfg_ready;
  logic                  out_strobe;
  logic [COORD_W-1:0]    out_region_left;
  logic [COORD_W-1:0]    out_region_right;
  logic [TALLY_W-1:0]    out_region_reads;
  logic                  out_is_summary;
  logic [KEPT_W-1:0]     out_kept_count;
  logic                  out_table_overflow;
  logic                  out_last;

  int unsigned words_due;
  int unsigned fail_count;
  int unsigned quiet_cycles = 0;
  int unsigned gap_pct = 0;
  int unsigned reads_sent = 0;
  int unsigned phase_mark;
  int unsigned roll;
  logic [SPAN_W-1:0] cur_span = READ_SPAN_RST;

  logic [SPAN_W-1:0]  phase_span  [PHASES] = '{10'd1023, 10'd1, 10'd0, 10'd200,
                                               10'd517, 10'd700};
  logic [LIMIT_W-1:0] phase_limit [PHASES] = '{16'd0, 16'd65535, 16'd65535, 16'd2,
                                               16'd1, 16'd3};
  int unsigned        phase_gap   [3]      = '{0, 81, 17};

  read_pileup_region_clusterer_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_read_position   (in_read_position),
    .in_last_read       (in_last_read),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_strobe         (out_strobe),
    .out_region_left    (out_region_left),
    .out_region_right   (out_region_right),
    .out_region_reads   (out_region_reads),
    .out_is_summary     (out_is_summary),
    .out_kept_count     (out_kept_count),
    .out_table_overflow (out_table_overflow),
    .out_last           (out_last)
  );

  region_report_checker report_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_read_position   (in_read_position),
    .in_last_read       (in_last_read),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_strobe         (out_strobe),
    .out_region_left    (out_region_left),
    .out_region_right   (out_region_right),
    .out_region_reads   (out_region_reads),
    .out_is_summary     (out_is_summary),
    .out_kept_count     (out_kept_count),
    .out_table_overflow (out_table_overflow),
    .out_last           (out_last),
    .words_due          (words_due),
    .fail_count         (fail_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // end the run when no word moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_read(logic [POS_W-1:0] pos, logic fin);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start            <= 1'b1;
    in_read_position <= pos;
    in_last_read     <= fin;
    do @(posedge clk); while (busy);
    reads_sent++;
  endtask

  // drop start, wait for every report word, then let the block go idle
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (words_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic hand_over(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic reconfigure(logic [SPAN_W-1:0] span, logic [LIMIT_W-1:0] limit,
                             bit poke_unmapped);
    settle();
    // upper data bits are junk for the span register
    hand_over(CFG_READ_SPAN, {6'($urandom), span});
    if (poke_unmapped) hand_over(CFG_UNMAPPED, CFG_DATA_W'($urandom));
    hand_over(CFG_MEAN_LIMIT, limit);
    cfg_valid <= 1'b0;
    cur_span = span;
  endtask

  task automatic play_run(run_kind_t kind, int unsigned count);
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] base;
    int unsigned      r;
    base = POS_W'($urandom_range(32'h7FF0_0000));
    pos  = base;
    for (int unsigned i = 0; i < count; i++) begin
      r = $urandom_range(9);
      case (kind)
        RUN_SCATTER: begin
          if (i != 0) pos += POS_W'(cur_span + $urandom_range(4000, 1));
        end
        RUN_SHUFFLED: begin
          pos = (r < 3) ? POS_W'($urandom) : base + POS_W'($urandom_range(3000));
        end
        default: begin
          if (i != 0 && r >= 3) begin
            if (r < 8) pos += POS_W'($urandom_range(cur_span));
            else pos += POS_W'(cur_span + $urandom_range(3000, 1));
          end
        end
      endcase
      send_read(pos, i == count - 1);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset settings: a lone read is far below the mean bar
    send_read('0, 1'b1);

    reconfigure(10'd1023, 16'd0, 1'b1);
    send_read(POS_TOP, 1'b1);
    // a chain whose later reads fall past the span limit
    for (int i = 0; i < 12; i++) send_read(POS_W'(4000 + 1000 * i), i == 11);

    // zero span: single-base regions with a width of zero
    reconfigure(10'd0, 16'd65535, 1'b0);
    send_read(POS_W'(12345), 1'b0);
    send_read(POS_W'(12345), 1'b0);
    send_read(POS_W'(12346), 1'b1);
    // out of order reads
    send_read(POS_W'(900), 1'b0);
    send_read(POS_W'(100), 1'b1);

    // base sum equal to the bar is not enough
    reconfigure(10'd4, 16'd5, 1'b0);
    repeat (3) send_read(POS_W'(7), 1'b0);
    send_read(POS_W'(7), 1'b1);

    for (int ph = 0; ph < PHASES; ph++) begin
      gap_pct = phase_gap[ph % 3];
      reconfigure(phase_span[ph], phase_limit[ph], ph == 3);
      phase_mark = reads_sent;
      while (reads_sent - phase_mark < RANDOM_READS / PHASES) begin
        if ($urandom_range(3) == 0) begin
          reconfigure(SPAN_W'($urandom_range(1023)),
                      ($urandom_range(4) == 0) ? LIMIT_W'($urandom)
                                               : LIMIT_W'($urandom_range(6)),
                      $urandom_range(7) == 0);
        end
        roll = $urandom_range(99);
        if (roll < 8) play_run(RUN_SCATTER, $urandom_range(40, 33));
        else if (roll < 25) play_run(RUN_SHUFFLED, $urandom_range(8, 2));
        else play_run(RUN_PILEUP, $urandom_range(14, 2));
      end
    end

    settle();
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
